@@ sv/lsbr_pkg.sv @@
// Shared types and constants of the LSB-first bit reader.
`default_nettype none

package lsbr_pkg;

    localparam int VALUE_W = 32;
    localparam int CNT_W   = 6;
    localparam int OFF_W   = 17;

    // a 32-bit read starting at bit 7 of a byte spans five bytes
    localparam int GATHER_BYTES = (VALUE_W + 7 + 7) / 8;
    localparam int GATHER_W     = GATHER_BYTES * 8;
    localparam int GK_W         = $clog2(GATHER_BYTES + 1);

    // queue between decode and execute; depth must stay a power of two
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_PEEK   = 2'd2;
    localparam logic [1:0] CMD_SEEK   = 2'd3;

    localparam logic [1:0] ORG_START   = 2'd0;
    localparam logic [1:0] ORG_CURRENT = 2'd1;
    localparam logic [1:0] ORG_END     = 2'd2;
    localparam logic [1:0] ORG_BAD     = 2'd3;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_BAD   = 2'd1;
    localparam logic [1:0] STS_RANGE = 2'd2;
    localparam logic [1:0] STS_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]              command;
        logic                    bad_arg;
        logic [7:0]              data_byte;
        logic [CNT_W-1:0]        bit_count;
        logic [1:0]              seek_origin;
        logic signed [OFF_W-1:0] bit_offset;
    } lsbr_item_t;

endpackage

`default_nettype wire

@@ sv/lsbr_front.sv @@
// Command decode: flags bad counts and bad seek origins before queueing.
`default_nettype none

module lsbr_front #(
    parameter int MAX_READ_BITS = 32
) (
    input  logic [1:0]                      command,
    input  logic [7:0]                      data_byte,
    input  logic [lsbr_pkg::CNT_W-1:0]      bit_count,
    input  logic [1:0]                      seek_origin,
    input  logic signed [lsbr_pkg::OFF_W-1:0] bit_offset,
    output lsbr_pkg::lsbr_item_t            item
);
    import lsbr_pkg::*;

    localparam logic [CNT_W:0] MAX_CNT = (CNT_W + 1)'(MAX_READ_BITS);

    logic count_bad;

    assign count_bad = (bit_count == '0) || ({1'b0, bit_count} > MAX_CNT);

    always_comb
    begin
        item.command     = command;
        item.data_byte   = data_byte;
        item.bit_count   = bit_count;
        item.seek_origin = seek_origin;
        item.bit_offset  = bit_offset;
        unique case (command)
            CMD_READ, CMD_PEEK: item.bad_arg = count_bad;
            CMD_SEEK:           item.bad_arg = (seek_origin == ORG_BAD);
            CMD_APPEND:         item.bad_arg = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/lsbr_queue.sv @@
// Small FIFO of decoded transactions between decode and execute.
`default_nettype none

module lsbr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lsbr_pkg::lsbr_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output lsbr_pkg::lsbr_item_t pop_item
);
    import lsbr_pkg::*;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    lsbr_item_t          entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push_en, pop_en;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign push_en   = push && !full;
    assign pop_en    = pop && not_empty;
    assign pop_item  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_en && !pop_en)
            count_next = count_reg + 1'b1;
        else if (pop_en && !push_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
            entries_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

@@ sv/lsbr_exec.sv @@
// Execute unit: byte store, length and bit position, byte-serial gather, result register.
`default_nettype none

module lsbr_exec #(
    parameter int STORE_BYTES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  lsbr_pkg::lsbr_item_t          q_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lsbr_pkg::VALUE_W-1:0]  value,
    output logic [1:0]                    status
);
    import lsbr_pkg::*;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int LEN_W  = $clog2(STORE_BYTES + 1);
    localparam int POS_W  = LEN_W + 3;
    localparam int TGT_W  = ((POS_W > OFF_W - 1) ? POS_W : OFF_W - 1) + 2;
    localparam int MASK_W = VALUE_W + 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(STORE_BYTES);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_FETCH = 1'b1;

    logic [7:0] mem [STORE_BYTES];

    logic                 state_reg, state_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [ADDR_W-1:0]    base_addr_reg, base_addr_next;
    logic [2:0]           shift_reg, shift_next;
    logic [CNT_W-1:0]     cnt_eff_reg, cnt_eff_next;
    logic [GK_W-1:0]      nbytes_reg, nbytes_next;
    logic [GK_W-1:0]      issue_k_reg, issue_k_next;
    logic [GK_W-1:0]      cap_k_reg, cap_k_next;
    logic [GATHER_W-1:0]  acc_reg, acc_next, acc_now;
    logic [7:0]           rd_data_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [1:0]           status_reg, status_next;

    logic                 wr_en, rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [POS_W-1:0]     stream_bits, remaining;
    logic [LEN_W-1:0]     pos_byte;
    logic                 out_free, range_ok;
    logic [CNT_W-1:0]     cnt_eff;
    logic [CNT_W:0]       need_bits;
    logic [GK_W-1:0]      nbytes;
    logic [POS_W-1:0]     seek_base;
    logic signed [TGT_W-1:0] target, total_s;
    logic                 seek_ok;
    logic [MASK_W-1:0]    mask_wide;
    logic [VALUE_W-1:0]   gathered;
    logic                 emit;
    logic [1:0]           emit_status;

    assign stream_bits = {len_reg, 3'b000};
    assign remaining   = stream_bits - pos_reg;
    assign pos_byte    = pos_reg[POS_W-1:3];
    assign out_free    = !out_valid_reg || !out_stall;
    assign q_pop       = (state_reg == S_IDLE) && q_valid && out_free;
    assign range_ok    = (pos_reg <= stream_bits) && (remaining >= POS_W'(q_item.bit_count));

    // only the first VALUE_W bits reach the result
    assign cnt_eff   = (q_item.bit_count > CNT_W'(VALUE_W)) ? CNT_W'(VALUE_W)
                                                            : q_item.bit_count;
    assign need_bits = {{(CNT_W - 2){1'b0}}, pos_reg[2:0]} + {1'b0, cnt_eff};
    assign nbytes    = GK_W'((need_bits + (CNT_W + 1)'(7)) >> 3);

    always_comb
    begin
        unique case (q_item.seek_origin)
            ORG_START:   seek_base = '0;
            ORG_CURRENT: seek_base = pos_reg;
            ORG_END:     seek_base = stream_bits;
            ORG_BAD:     seek_base = '0;
        endcase
    end

    assign target  = $signed({{(TGT_W - POS_W){1'b0}}, seek_base}) + TGT_W'(q_item.bit_offset);
    assign total_s = $signed({{(TGT_W - POS_W){1'b0}}, stream_bits});
    assign seek_ok = (target >= 0) && (target <= total_s);

    // merge the byte arriving this cycle into the gather word
    always_comb
    begin
        acc_now = acc_reg;
        acc_now[cap_k_reg * 8 +: 8] = rd_data_reg;
    end

    assign mask_wide = (MASK_W'(1) << cnt_eff_reg) - MASK_W'(1);
    assign gathered  = VALUE_W'(acc_now >> shift_reg) & mask_wide[VALUE_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        base_addr_next = base_addr_reg;
        shift_next     = shift_reg;
        cnt_eff_next   = cnt_eff_reg;
        nbytes_next    = nbytes_reg;
        issue_k_next   = issue_k_reg;
        cap_k_next     = cap_k_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = base_addr_reg;
        emit           = 1'b0;
        emit_status    = STS_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    priority if (q_item.command == CMD_APPEND)
                    begin
                        emit = 1'b1;
                        if (len_reg == LEN_MAX)
                            emit_status = STS_FULL;
                        else
                        begin
                            wr_en    = 1'b1;
                            len_next = len_reg + 1'b1;
                        end
                    end
                    else if (len_reg == '0 || q_item.bad_arg)
                    begin
                        emit        = 1'b1;
                        emit_status = STS_BAD;
                    end
                    else if (q_item.command == CMD_SEEK)
                    begin
                        emit = 1'b1;
                        if (seek_ok)
                            pos_next = target[POS_W-1:0];
                        else
                            emit_status = STS_RANGE;
                    end
                    else if (!range_ok)
                    begin
                        emit        = 1'b1;
                        emit_status = STS_RANGE;
                        if (q_item.command == CMD_READ)
                            pos_next = stream_bits;
                    end
                    else
                    begin
                        // first byte goes out now; the rest follow one per cycle
                        rd_en          = 1'b1;
                        rd_addr        = pos_byte[ADDR_W-1:0];
                        base_addr_next = pos_byte[ADDR_W-1:0];
                        shift_next     = pos_reg[2:0];
                        cnt_eff_next   = cnt_eff;
                        nbytes_next    = nbytes;
                        issue_k_next   = GK_W'(1);
                        cap_k_next     = '0;
                        acc_next       = '0;
                        state_next     = S_FETCH;
                        if (q_item.command == CMD_READ)
                            pos_next = pos_reg + POS_W'(q_item.bit_count);
                    end
                end
            end
            S_FETCH:
            begin
                acc_next   = acc_now;
                cap_k_next = cap_k_reg + 1'b1;
                if (issue_k_reg < nbytes_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = base_addr_reg + ADDR_W'(issue_k_reg);
                    issue_k_next = issue_k_reg + 1'b1;
                end
                if (cap_k_reg == nbytes_reg - 1'b1)
                begin
                    out_valid_next = 1'b1;
                    value_next     = gathered;
                    status_next    = STS_OK;
                    state_next     = S_IDLE;
                end
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            value_next     = '0;
            status_next    = emit_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_addr_reg <= base_addr_next;
        shift_reg     <= shift_next;
        cnt_eff_reg   <= cnt_eff_next;
        nbytes_reg    <= nbytes_next;
        issue_k_reg   <= issue_k_next;
        cap_k_reg     <= cap_k_next;
        acc_reg       <= acc_next;
        value_reg     <= value_next;
        status_reg    <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[len_reg[ADDR_W-1:0]] <= q_item.data_byte;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

@@ sv/lsb_first_bit_reader.sv @@
// Top level of the LSB-first bit reader: decode, transaction queue and execute unit.
//
// Appends bytes to an internal store and reads 1 to MAX_READ_BITS bits least
// significant bit first from a bit position, with peek and seek. Each input
// transaction yields exactly one result (value, status). Decoded transactions
// wait in a two-entry queue, so input is taken while a result is still stalled.
// Append, seek and every failing command complete in the idle state of the execute
// unit; a successful read or peek then fetches the 1 to 5 bytes its bit span
// touches in the fetch state, one byte per cycle, since the byte-wide store has a
// single registered read port. Store contents are not cleared at reset; reads
// stay within the appended length, so no clearing pass is needed.
`default_nettype none

module lsb_first_bit_reader #(
    parameter int STORE_BYTES   = 4096,
    parameter int MAX_READ_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        command,
    input  logic [7:0]                        data_byte,
    input  logic [lsbr_pkg::CNT_W-1:0]        bit_count,
    input  logic [1:0]                        seek_origin,
    input  logic signed [lsbr_pkg::OFF_W-1:0] bit_offset,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lsbr_pkg::VALUE_W-1:0]      value,
    output logic [1:0]                        status
);
    import lsbr_pkg::*;

    lsbr_item_t dec_item, q_item;
    logic       q_full, q_valid, q_pop;

    lsbr_front #(
        .MAX_READ_BITS(MAX_READ_BITS)
    ) u_front (
        .command    (command),
        .data_byte  (data_byte),
        .bit_count  (bit_count),
        .seek_origin(seek_origin),
        .bit_offset (bit_offset),
        .item       (dec_item)
    );

    lsbr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_valid),
        .push_item(dec_item),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_valid),
        .pop_item (q_item)
    );

    lsbr_exec #(
        .STORE_BYTES(STORE_BYTES)
    ) u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .value    (value),
        .status   (status)
    );

    assign in_stall = q_full;

endmodule

`default_nettype wire

@@ sv/lsbr_checker.sv @@
// Port-level checks of the bit reader and the bind that attaches them.
`default_nettype none

module lsbr_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [lsbr_pkg::VALUE_W-1:0] value,
    input  logic [1:0]                   status
);
    import lsbr_pkg::*;

    // queue entries plus one transaction in execute or in the result register
    localparam int MAX_INFLIGHT = QUEUE_DEPTH + 1;
    localparam int IF_W         = $clog2(MAX_INFLIGHT + 2);

    logic [IF_W-1:0] inflight_reg, inflight_next;
    logic            in_acc, out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
            inflight_next = inflight_reg + 1'b1;
        else if (out_acc && !in_acc)
            inflight_next = inflight_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STS_OK |-> value == '0)
        else $error("failing transaction returned a nonzero value");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != '0)
        else $error("result without a pending input transaction");

    a_inflight_cap: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= IF_W'(MAX_INFLIGHT))
        else $error("more transactions in flight than the design can hold");

endmodule

bind lsb_first_bit_reader lsbr_checker u_lsbr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value    (value),
    .status   (status)
);

`default_nettype wire

@@ tb/tb_lsb_first_bit_reader.sv @@
// Self-checking testbench of the LSB-first bit reader: directed table and random traffic.
`timescale 1ns / 100ps

module tb_lsb_first_bit_reader;

    import lsbr_pkg::*;

    localparam int STORE_BYTES   = 4096;
    localparam int MAX_READ_BITS = 32;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 32;

    typedef struct {
        logic [1:0]              command;
        logic [7:0]              data_byte;
        logic [CNT_W-1:0]        bit_count;
        logic [1:0]              seek_origin;
        logic signed [OFF_W-1:0] bit_offset;
        bit                      fixed;      // expected result given in the table
        logic [VALUE_W-1:0]      value;
        logic [1:0]              status;
    } reader_cmd_t;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [1:0]         status;
    } reader_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              command;
    logic [7:0]              data_byte;
    logic [CNT_W-1:0]        bit_count;
    logic [1:0]              seek_origin;
    logic signed [OFF_W-1:0] bit_offset;
    logic                    out_valid;
    logic                    out_stall;
    logic [VALUE_W-1:0]      value;
    logic [1:0]              status;

    // shadow of the block's state
    logic [7:0]  shadow_bytes [STORE_BYTES];
    int unsigned shadow_len;
    int unsigned shadow_pos;

    reader_result_t pending_results [$];
    reader_cmd_t    table_rows [$];

    int mismatch_count;
    int cycle_count;
    int stall_left;
    bit no_idle;

    lsb_first_bit_reader #(
        .STORE_BYTES   (STORE_BYTES),
        .MAX_READ_BITS (MAX_READ_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .data_byte   (data_byte),
        .bit_count   (bit_count),
        .seek_origin (seek_origin),
        .bit_offset  (bit_offset),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .status      (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Applies one transaction to the shadow state and returns what the block must answer.
    task automatic reader_step(input reader_cmd_t it, output reader_result_t res);
        int unsigned stream_bits;
        int unsigned p;
        int          base;
        int          target;
        res.value   = '0;
        res.status  = STS_OK;
        stream_bits = shadow_len * 8;
        if (it.command == CMD_APPEND)
        begin
            if (shadow_len >= STORE_BYTES)
                res.status = STS_FULL;
            else
            begin
                shadow_bytes[shadow_len] = it.data_byte;
                shadow_len++;
            end
        end
        else if (shadow_len == 0)
            res.status = STS_BAD;
        else if (it.command == CMD_READ || it.command == CMD_PEEK)
        begin
            if (it.bit_count == 0 || it.bit_count > MAX_READ_BITS)
                res.status = STS_BAD;
            else if (stream_bits - shadow_pos < it.bit_count)
            begin
                res.status = STS_RANGE;
                if (it.command == CMD_READ)
                    shadow_pos = stream_bits;
            end
            else
            begin
                for (int k = 0; k < it.bit_count; k++)
                begin
                    p = shadow_pos + k;
                    res.value[k] = shadow_bytes[p >> 3][p & 7];
                end
                if (it.command == CMD_READ)
                    shadow_pos += it.bit_count;
            end
        end
        else if (it.seek_origin == ORG_BAD)
            res.status = STS_BAD;
        else
        begin
            case (it.seek_origin)
                ORG_START:   base = 0;
                ORG_CURRENT: base = shadow_pos;
                default:     base = stream_bits;
            endcase
            target = base + int'(it.bit_offset);
            if (target < 0 || target > int'(stream_bits))
                res.status = STS_RANGE;
            else
                shadow_pos = target;
        end
    endtask

    function automatic reader_cmd_t table_row(input logic [1:0] cmd, input logic [7:0] byte_in,
                                              input int cnt, input logic [1:0] org, input int off,
                                              input int fixed, input logic [VALUE_W-1:0] val,
                                              input logic [1:0] sts);
        reader_cmd_t r;
        r.command     = cmd;
        r.data_byte   = byte_in;
        r.bit_count   = CNT_W'(cnt);
        r.seek_origin = org;
        r.bit_offset  = OFF_W'(off);
        r.fixed       = (fixed != 0);
        r.value       = val;
        r.status      = sts;
        return r;
    endfunction

    // Mostly legal counts and in-range seeks; the rest is random noise.
    function automatic reader_cmd_t pick_cmd(input int append_pct);
        reader_cmd_t it;
        int          r;
        int          base;
        int          target;
        int unsigned stream_bits;
        stream_bits    = shadow_len * 8;
        it.command     = CMD_APPEND;
        it.data_byte   = 8'($urandom);
        it.bit_count   = CNT_W'($urandom);
        it.seek_origin = 2'($urandom);
        it.bit_offset  = OFF_W'($urandom);
        it.fixed       = 1'b0;
        it.value       = '0;
        it.status      = STS_OK;
        if ($urandom_range(0, 99) >= append_pct)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                it.command = CMD_READ;
            else if (r < 75)
                it.command = CMD_PEEK;
            else
                it.command = CMD_SEEK;
            if (it.command != CMD_SEEK)
            begin
                if ($urandom_range(0, 9) != 0)
                    it.bit_count = CNT_W'($urandom_range(1, MAX_READ_BITS));
            end
            else if ($urandom_range(0, 19) != 0)
            begin
                it.seek_origin = 2'($urandom_range(0, 2));
                if ($urandom_range(0, 9) != 0)
                begin
                    target = $urandom_range(0, stream_bits);
                    case (it.seek_origin)
                        ORG_START:   base = 0;
                        ORG_CURRENT: base = shadow_pos;
                        default:     base = stream_bits;
                    endcase
                    it.bit_offset = OFF_W'(target - base);
                end
            end
        end
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction is taken.
    task automatic send_cmd(input reader_cmd_t it);
        reader_result_t res;
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= it.command;
        data_byte   <= it.data_byte;
        bit_count   <= it.bit_count;
        seek_origin <= it.seek_origin;
        bit_offset  <= it.bit_offset;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        reader_step(it, res);
        if (it.fixed)
        begin
            res.value  = it.value;
            res.status = it.status;
        end
        pending_results.push_back(res);
        @(negedge clk);
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    always @(negedge clk)
    begin
        if (!no_idle && stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (!no_idle && rst_n && $urandom_range(0, 9) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 18);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        reader_result_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with none expected: value %h status %0d",
                       value, status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (value !== want.value)
                begin
                    $error("value: expected %h, got %h", want.value, value);
                    mismatch_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        command        = CMD_APPEND;
        data_byte      = '0;
        bit_count      = '0;
        seek_origin    = ORG_START;
        bit_offset     = '0;
        stall_left     = 0;
        no_idle        = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        shadow_len     = 0;
        shadow_pos     = 0;

        // empty store, bad counts, exhaustion, seek bounds, append at the end
        table_rows.push_back(table_row(CMD_READ,   8'hFF,  8, ORG_START,        0, 1, 0, STS_BAD));
        table_rows.push_back(table_row(CMD_PEEK,   8'h00, 32, ORG_START,        0, 1, 0, STS_BAD));
        table_rows.push_back(table_row(CMD_SEEK,   8'h00,  1, ORG_START,        0, 1, 0, STS_BAD));
        table_rows.push_back(table_row(CMD_APPEND, 8'h00,  0, ORG_START,        0, 1, 0, STS_OK));
        table_rows.push_back(table_row(CMD_APPEND, 8'hFF, 63, ORG_BAD,         -1, 1, 0, STS_OK));
        table_rows.push_back(table_row(CMD_APPEND, 8'hA5,  0, ORG_START,        0, 1, 0, STS_OK));
        table_rows.push_back(table_row(CMD_APPEND, 8'h3C,  0, ORG_START,        0, 1, 0, STS_OK));
        table_rows.push_back(table_row(CMD_APPEND, 8'h81,  0, ORG_START,        0, 1, 0, STS_OK));
        table_rows.push_back(table_row(CMD_READ,   8'h00,  0, ORG_START,        0, 1, 0, STS_BAD));
        table_rows.push_back(table_row(CMD_PEEK,   8'h00, 63, ORG_START,        0, 1, 0, STS_BAD));
        table_rows.push_back(table_row(CMD_READ,   8'h00, 33, ORG_START,        0, 1, 0, STS_BAD));
        table_rows.push_back(table_row(CMD_PEEK,   8'h00, 32, ORG_START,        0, 0, 0, STS_OK));
        table_rows.push_back(table_row(CMD_READ,   8'h00,  1, ORG_START,        0, 0, 0, STS_OK));
        table_rows.push_back(table_row(CMD_READ,   8'h00, 32, ORG_START,        0, 0, 0, STS_OK));
        table_rows.push_back(table_row(CMD_READ,   8'h00,  8, ORG_START,        0, 1, 0, STS_RANGE));
        table_rows.push_back(table_row(CMD_PEEK,   8'h00,  1, ORG_START,        0, 1, 0, STS_RANGE));
        table_rows.push_back(table_row(CMD_SEEK,   8'h00,  0, ORG_BAD,          0, 1, 0, STS_BAD));
        table_rows.push_back(table_row(CMD_SEEK,   8'h00,  0, ORG_START,       -1, 1, 0, STS_RANGE));
        table_rows.push_back(table_row(CMD_SEEK,   8'h00,  0, ORG_END,          1, 1, 0, STS_RANGE));
        table_rows.push_back(table_row(CMD_SEEK,   8'h00,  0, ORG_START,    65535, 1, 0, STS_RANGE));
        table_rows.push_back(table_row(CMD_SEEK,   8'h00,  0, ORG_CURRENT, -65536, 1, 0, STS_RANGE));
        table_rows.push_back(table_row(CMD_APPEND, 8'h5A,  0, ORG_START,        0, 1, 0, STS_OK));
        table_rows.push_back(table_row(CMD_READ,   8'h00,  8, ORG_START,        0, 0, 0, STS_OK));
        table_rows.push_back(table_row(CMD_SEEK,   8'h00,  0, ORG_START,        7, 1, 0, STS_OK));
        table_rows.push_back(table_row(CMD_PEEK,   8'h00, 32, ORG_START,        0, 0, 0, STS_OK));
        table_rows.push_back(table_row(CMD_SEEK,   8'h00,  0, ORG_END,        -48, 1, 0, STS_OK));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (table_rows[i])
            send_cmd(table_rows[i]);
        wait_results_done();

        for (int n = 0; n < 460; n++)
        begin
            send_cmd(pick_cmd(30));
            // hold the sender back until the block has answered everything
            if (n % 150 == 149)
                wait_results_done();
        end

        // no input idling and no output stalls from here on
        no_idle = 1'b1;
        for (int n = 0; n < 120; n++)
            send_cmd(pick_cmd(20));

        wait_results_done();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
